[hdl/sha256_pkg.sv]
// Package: SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 61;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam int unsigned LenPos     = 56;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

[hdl/sha256_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[hdl/sha256_message_digest.sv]
// SHA-256 top level: byte intake, block memory, round engine, digest output.
// Message bytes arrive one per request and go into a 64-byte block RAM; a
// byte request that does not complete a block leaves the block ready for
// the next request. A byte that fills the block starts a compression: the
// 64 bytes are copied into the 16-word schedule RAM, then 64 rounds follow.
// Rounds 0..15 go through read, latch and apply. Rounds 16..63 take longer,
// because the four schedule reads share one RAM port, then the new word is
// written back and the round is applied. ST_ADD then adds into the chaining
// state. No request is taken while a block is compressed. On end of message
// the padding is written one byte per cycle, from the byte count modulo 64
// up to byte 63, and a compression follows. If the 0x80 byte lands at byte
// 56 or later, a second padding pass over the whole block and a compression
// follow. When the ending byte fills a block, that block is compressed first
// and then one full padding block follows. Then eight digest words are sent,
// word 0 first, one per cycle while out_ready_i is high, the last one flagged,
// and the block clears its count and reloads the initial chaining state.
`default_nettype none
module sha256_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  input  wire logic        message_empty_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic              final_q;      // message has ended, padding follows
  logic              second_q;     // padding pass of the spill block
  logic              last_blk_q;   // block in flight is the final one
  logic [6:0]        step_q;       // load step
  logic [5:0]        rnd_q;        // round number
  logic [2:0]        sub_q;        // round sub-step
  logic [5:0]        pad_pos_q;
  logic [2:0]        emit_q;
  word_t             hash_q [8];
  word_t             v_q [8];
  word_t             wacc_q;       // byte assembly during load
  word_t             w_q;          // schedule word of the current round
  word_t             x16_q, x15_q, x2_q;

  // Block RAM
  logic       buf_we;
  logic [5:0] buf_addr;
  logic [7:0] buf_wdata, buf_rdata;
  sha256_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
    .clk_i, .we_i(buf_we), .addr_i(buf_addr), .wdata_i(buf_wdata), .rdata_o(buf_rdata)
  );

  // Schedule RAM
  logic       w_we;
  logic [3:0] w_addr;
  word_t      w_wdata, w_rdata;
  sha256_ram #(.Width(WordW), .Depth(16)) u_win (
    .clk_i, .we_i(w_we), .addr_i(w_addr), .wdata_i(w_wdata), .rdata_o(w_rdata)
  );

  logic        accept;
  logic [5:0]  pos;
  logic [63:0] bitlen;
  logic        pad_spill;
  logic [7:0]  len_byte;
  logic        rnd_apply;
  word_t       g0, g1, w_new, t1, t2, s0, s1, ch, maj;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign pos        = count_q[5:0];
  assign bitlen     = {count_q, 3'b000};
  // 0x80 at byte 56 or later: the length goes into a second block
  assign pad_spill  = (pos >= 6'(LenPos));
  assign len_byte   = 8'(bitlen >> {3'd7 - pad_pos_q[2:0], 3'b000});
  assign rnd_apply  = (state_q == ST_ROUND) && (sub_q == 3'd5);

  // Schedule expansion and round function
  assign g0    = rotr(x15_q, 7) ^ rotr(x15_q, 18) ^ (x15_q >> 3);
  assign g1    = rotr(x2_q, 17) ^ rotr(x2_q, 19) ^ (x2_q >> 10);
  assign w_new = x16_q + g0 + w_rdata + g1;
  assign s1    = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign s0    = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2    = s0 + maj;
  assign t1    = v_q[7] + s1 + ch + round_k(rnd_q) + w_q;

  // Memory address and write control
  always_comb begin
    buf_we    = 1'b0;
    buf_addr  = pos;
    buf_wdata = data_byte_i;
    w_we      = 1'b0;
    w_addr    = rnd_q[3:0];
    w_wdata   = w_new;
    unique case (state_q)
      ST_IDLE: begin
        buf_we = accept && !message_empty_i;
      end
      ST_PAD: begin
        buf_we   = 1'b1;
        buf_addr = pad_pos_q;
        if (!second_q && pad_pos_q == pos) begin
          buf_wdata = PadByte;
        end else if (pad_pos_q >= 6'(LenPos) && (second_q || !pad_spill)) begin
          buf_wdata = len_byte;
        end else begin
          buf_wdata = 8'h00;
        end
      end
      ST_LOAD: begin
        // byte s arrives at step s+1; a word is written with its fourth byte
        buf_addr = step_q[5:0];
        w_we     = (step_q[1:0] == 2'd0) && (step_q != 7'd0);
        w_addr   = step_q[5:2] - 4'd1;
        w_wdata  = {wacc_q[23:0], buf_rdata};
      end
      ST_ROUND: begin
        // sub 0 reads i-16 (or i), 1 reads i-15, 2 reads i-2, 3 reads i-7
        case (sub_q)
          3'd1:    w_addr = rnd_q[3:0] + 4'd1;
          3'd2:    w_addr = rnd_q[3:0] + 4'd14;
          3'd3:    w_addr = rnd_q[3:0] + 4'd9;
          default: w_addr = rnd_q[3:0];
        endcase
        w_we = (sub_q == 3'd4);
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!message_empty_i && pos == 6'd63) state_d = ST_LOAD;
          else if (end_of_message_i) state_d = ST_PAD;
        end
      end
      ST_PAD:   if (pad_pos_q == 6'd63) state_d = ST_LOAD;
      ST_LOAD:  if (step_q == 7'd64) state_d = ST_ROUND;
      ST_ROUND: if (rnd_apply && rnd_q == 6'(Rounds - 1)) state_d = ST_ADD;
      ST_ADD: begin
        if (!final_q) state_d = ST_IDLE;
        else if (last_blk_q) state_d = ST_EMIT;
        else state_d = ST_PAD;
      end
      ST_EMIT:  if (out_ready_i && emit_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    out_valid_o   = (state_q == ST_EMIT);
    digest_word_o = hash_q[emit_q];
    word_index_o  = emit_q;
    last_word_o   = (emit_q == 3'd7);
  end

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      final_q    <= 1'b0;
      second_q   <= 1'b0;
      last_blk_q <= 1'b0;
      step_q     <= '0;
      rnd_q      <= '0;
      sub_q      <= '0;
      pad_pos_q  <= '0;
      emit_q     <= '0;
      wacc_q     <= '0;
      w_q        <= '0;
      x16_q      <= '0;
      x15_q      <= '0;
      x2_q       <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= init_hash(3'(i));
        v_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            final_q    <= end_of_message_i;
            second_q   <= 1'b0;
            last_blk_q <= 1'b0;
            step_q     <= '0;
            emit_q     <= '0;
            if (!message_empty_i) begin
              count_q   <= count_q + CountW'(1);
              pad_pos_q <= pos + 6'd1;
            end else begin
              pad_pos_q <= pos;
            end
          end
        end
        ST_PAD: begin
          pad_pos_q <= pad_pos_q + 6'd1;
          step_q    <= '0;
          if (pad_pos_q == 6'd63) begin
            last_blk_q <= second_q || !pad_spill;
            if (pad_spill) second_q <= 1'b1;
          end
        end
        ST_LOAD: begin
          step_q <= step_q + 7'd1;
          wacc_q <= {wacc_q[23:0], buf_rdata};
          if (step_q == 7'd64) begin
            rnd_q <= '0;
            sub_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
          end
        end
        ST_ROUND: begin
          case (sub_q)
            3'd0: sub_q <= 3'd1;
            3'd1: begin
              if (rnd_q < 6'd16) begin
                w_q   <= w_rdata;
                sub_q <= 3'd5;
              end else begin
                x16_q <= w_rdata;
                sub_q <= 3'd2;
              end
            end
            3'd2: begin
              x15_q <= w_rdata;
              sub_q <= 3'd3;
            end
            3'd3: begin
              x2_q  <= w_rdata;
              sub_q <= 3'd4;
            end
            3'd4: begin
              w_q   <= w_new;
              sub_q <= 3'd5;
            end
            3'd5: begin
              sub_q  <= 3'd0;
              rnd_q  <= rnd_q + 6'd1;
              v_q[7] <= v_q[6];
              v_q[6] <= v_q[5];
              v_q[5] <= v_q[4];
              v_q[4] <= v_q[3] + t1;
              v_q[3] <= v_q[2];
              v_q[2] <= v_q[1];
              v_q[1] <= v_q[0];
              v_q[0] <= t1 + t2;
            end
            default: sub_q <= 3'd0;
          endcase
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
          pad_pos_q <= '0;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            emit_q <= emit_q + 3'd1;
            if (emit_q == 3'd7) begin
              count_q <= '0;
              final_q <= 1'b0;
              for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while emitting");
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=> out_valid_o)
    else $error("digest words interrupted");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> in_ready_o)
    else $error("no return to idle after digest");
  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(digest_word_o) && $stable(word_index_o)))
    else $error("digest word changed while stalled");
`endif

endmodule
`default_nettype wire

[verif/sha256_message_digest_tb.sv]
// Testbench for the byte-serial SHA-256 digest block: predicted digests, random stalls.
`default_nettype none
module sha256_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       empty;
  } byte_req_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_t;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        message_empty_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_message_digest u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Known round constants and initial hash, typed in here rather than shared.
  word_t k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  word_t h_init [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Predictor state
  logic [7:0]  blk_bytes [64];
  logic [60:0] byte_cnt;
  word_t       hash_st [8];

  byte_req_t pending_reqs [$];
  digest_t   digest_q [$];
  int unsigned err_cnt, word_cnt, msg_cnt, req_cnt;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_send;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk_bytes into hash_st
  task automatic compress();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + k_tab[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  // Append one request to the pending queue
  task automatic append_req(byte_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  // Absorb one accepted request; on end of message pad and queue the digest
  task automatic absorb_request(byte_req_t r);
    int unsigned pos;
    logic [63:0] bits;
    digest_t d;
    if (!r.empty) begin
      pos = byte_cnt[5:0];
      blk_bytes[pos] = r.data;
      byte_cnt++;
      if (pos == 63) compress();
    end
    if (!r.eom) return;
    bits = {byte_cnt, 3'b000};
    pos = byte_cnt[5:0];
    blk_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) blk_bytes[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < 56) blk_bytes[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = hash_st[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      digest_q = {digest_q, d};
    end
    hash_st = h_init;
    byte_cnt = '0;
    msg_cnt++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  // Queue a message of n random bytes (n may be 0: empty end item)
  task automatic add_message(int unsigned n, bit stray_empty);
    byte_req_t r;
    for (int i = 0; i < n; i++) begin
      if (stray_empty && $urandom_range(0, 15) == 0) begin
        r = '{data: 8'($urandom), eom: 1'b0, empty: 1'b1};
        append_req(r);
      end
      r = '{data: 8'($urandom), eom: (i == n - 1), empty: 1'b0};
      append_req(r);
    end
    if (n == 0) append_req('{data: 8'($urandom), eom: 1'b1, empty: 1'b1});
  endtask

  // Driver: request side
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      absorb_request(pending_reqs.pop_front());
      req_cnt++;
    end
    if (in_valid_i && !in_ready_o) begin
      // hold payload
    end else if (pending_reqs.size() != 0 && !hold_send
                 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      data_byte_i <= pending_reqs[0].data;
      end_of_message_i <= pending_reqs[0].eom;
      message_empty_i <= pending_reqs[0].empty;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: result side
  always @(posedge clk_i) begin
    digest_t e;
    if (out_valid_o && out_ready_i) begin
      word_cnt++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", digest_word_o, '0);
      end else begin
        e = digest_q.pop_front();
        if (digest_word_o !== e.word) report_mismatch("digest_word", digest_word_o, e.word);
        if (word_index_o !== e.idx)
          report_mismatch("word_index", 32'(word_index_o), 32'(e.idx));
        if (last_word_o !== e.last)
          report_mismatch("last_word", 32'(last_word_o), 32'(e.last));
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: cycles without any handshake
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("sha256_message_digest regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || digest_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned lens [$];
    hash_st = h_init;
    byte_cnt = '0;
    send_idle_pct = 17;
    recv_idle_pct = 65;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, extreme bytes, empty with end after bytes,
    // empty without end mid-message, a one-byte message
    add_message(0, 0);
    append_req('{data: 8'h00, eom: 1'b0, empty: 1'b0});
    append_req('{data: 8'hff, eom: 1'b0, empty: 1'b1});
    append_req('{data: 8'hff, eom: 1'b1, empty: 1'b0});
    append_req('{data: 8'h61, eom: 1'b0, empty: 1'b0});
    append_req('{data: 8'h62, eom: 1'b0, empty: 1'b0});
    append_req('{data: 8'h00, eom: 1'b1, empty: 1'b1});
    add_message(1, 0);
    // Pause until every digest word of the directed part has come back
    hold_send = 1;
    @(posedge clk_i);
    hold_send = 0;
    wait_drained();
    hold_send = 1;
    repeat (20) @(posedge clk_i);
    hold_send = 0;

    // Random: lengths near the one- and two-block padding edges, plus short ones
    lens = '{55, 56, 63, 64, 0, 3, 71, 2, 12, 9, 5, 1, 20, 17, 0, 7};
    foreach (lens[i]) begin
      if (i == 6) begin
        wait_drained();
        send_idle_pct = 65;
        recv_idle_pct = 17;
      end
      if (i == 11) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      add_message(lens[i], 1);
    end
    for (int i = 0; i < 8; i++) add_message($urandom_range(0, 4), 1);
    wait_drained();
    $display("covered %0d requests, %0d messages, %0d digest words checked",
             req_cnt, msg_cnt, word_cnt);
    $display("lengths spanned empty, padding edges 55/56/63/64 and two-block messages");
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) $display("sha256_message_digest regression: pass");
    else $display("sha256_message_digest regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
